[hw/rtl/tce_pkg.sv]
// Shared types and constants for the touch channel evaluator.
`timescale 1ns / 1ps
package tce_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIMER_MODE_MASK  = 3'd0,
    REG_HOLD_MARGIN      = 3'd1,
    REG_ENTER_MARGIN     = 3'd2,
    REG_BASELINE_STEP    = 3'd3,
    REG_SHORT_HOLD_TICKS = 3'd4,
    REG_LONG_HOLD_TICKS  = 3'd5,
    REG_DEBOUNCE_LENGTH  = 3'd6,
    REG_WARMUP_TICKS     = 3'd7
  } cfg_reg_t;

  localparam int READING_W = 13;
  localparam int MARGIN_W  = 10;
  localparam int CFG_W     = 10;

  localparam logic [READING_W-1:0] BASELINE_MAX = 13'h1fff;
  localparam logic [7:0]           HIST_MAX     = 8'hff;

  // Event codes (real and timer mode share the numbering space)
  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_ON_EDGE     = 2'd1;
  localparam logic [1:0] EV_OFF_EDGE    = 2'd2;
  localparam logic [1:0] EV_SHORT_PRESS = 2'd1;
  localparam logic [1:0] EV_LONG_MATCH  = 2'd2;
  localparam logic [1:0] EV_SHORT_MATCH = 2'd3;

  // Register reset values
  localparam logic [3:0]          RST_TIMER_MODE_MASK  = 4'd0;
  localparam logic [MARGIN_W-1:0] RST_HOLD_MARGIN      = 10'd80;
  localparam logic [MARGIN_W-1:0] RST_ENTER_MARGIN     = 10'd160;
  localparam logic [3:0]          RST_BASELINE_STEP    = 4'd3;
  localparam logic [7:0]          RST_SHORT_HOLD_TICKS = 8'd10;
  localparam logic [7:0]          RST_LONG_HOLD_TICKS  = 8'd100;
  localparam logic [2:0]          RST_DEBOUNCE_LENGTH  = 3'd3;
  localparam logic [7:0]          RST_WARMUP_TICKS     = 8'd150;

endpackage

[hw/rtl/touch_channel_evaluator_core.sv]
// Touch channel evaluator: baseline tracking, hysteresis and edge/hold events.
`timescale 1ns / 1ps
// One request is taken per clock while the output register is empty or being
// read; each request returns exactly one event_code. A request first lands in
// an input register; when it advances, it updates its channel's baseline and
// history, and its event_code moves into the output register. The rate is
// set by the read-modify-write, as a request advances, of the per-channel
// baseline and history registers. All state is cleared by rst, no clearing
// pass is needed. The first warmup_ticks requests after reset only count and
// return 0; channels at or above CHANNELS return 0 and leave state alone.
// Configuration writes are meant to happen while no request is in flight.
module touch_channel_evaluator_core
  import tce_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           channel,
  input  logic [READING_W-1:0] summed_reading,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           event_code
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [3:0]          timer_mode_mask;
  logic [MARGIN_W-1:0] hold_margin;
  logic [MARGIN_W-1:0] enter_margin;
  logic [3:0]          baseline_step;
  logic [7:0]          short_hold_ticks;
  logic [7:0]          long_hold_ticks;
  logic [2:0]          debounce_length;
  logic [7:0]          warmup_ticks;

  // state
  logic [7:0]           warmup_count;
  logic [READING_W-1:0] baseline [CHANNELS];
  logic [7:0]           history  [CHANNELS];

  // input stage
  logic                 s1_valid;
  logic [2:0]           s1_channel;
  logic [READING_W-1:0] s1_reading;

  logic                 adv;
  logic                 warm;
  logic                 ch_valid;
  logic [CH_W-1:0]      idx;
  logic                 timer_mode;
  logic [7:0]           tm_ext;
  logic [READING_W-1:0] base_cur;
  logic [READING_W:0]   base_sum;
  logic [READING_W-1:0] baseline_next;
  logic [7:0]           hist_cur;
  logic [7:0]           history_next;
  logic [7:0]           hist_shift;
  logic [7:0]           hist_inc;
  logic [MARGIN_W-1:0]  margin;
  logic [READING_W:0]   thresh;
  logic                 touch_on;
  logic [2:0]           deb_len;
  logic [3:0]           deb_len_p1;
  logic [8:0]           mask9;
  logic [8:0]           pat_on9;
  logic [7:0]           hist_masked;
  logic [1:0]           code;
  logic                 st_we;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_mode_mask  <= RST_TIMER_MODE_MASK;
      hold_margin      <= RST_HOLD_MARGIN;
      enter_margin     <= RST_ENTER_MARGIN;
      baseline_step    <= RST_BASELINE_STEP;
      short_hold_ticks <= RST_SHORT_HOLD_TICKS;
      long_hold_ticks  <= RST_LONG_HOLD_TICKS;
      debounce_length  <= RST_DEBOUNCE_LENGTH;
      warmup_ticks     <= RST_WARMUP_TICKS;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMER_MODE_MASK:  timer_mode_mask  <= cfg_data[3:0];
        REG_HOLD_MARGIN:      hold_margin      <= cfg_data;
        REG_ENTER_MARGIN:     enter_margin     <= cfg_data;
        REG_BASELINE_STEP:    baseline_step    <= cfg_data[3:0];
        REG_SHORT_HOLD_TICKS: short_hold_ticks <= cfg_data[7:0];
        REG_LONG_HOLD_TICKS:  long_hold_ticks  <= cfg_data[7:0];
        REG_DEBOUNCE_LENGTH:  debounce_length  <= cfg_data[2:0];
        REG_WARMUP_TICKS:     warmup_ticks     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_channel <= channel;
      s1_reading <= summed_reading;
    end
  end

  always_comb begin
    warm     = warmup_count < warmup_ticks;
    ch_valid = {1'b0, s1_channel} < 4'(CHANNELS);
    idx      = s1_channel[CH_W-1:0];
    tm_ext   = 8'(timer_mode_mask);
    timer_mode = tm_ext[s1_channel];
    base_cur = baseline[idx];
    hist_cur = history[idx];

    // baseline: load when empty or on a lower reading, creep up otherwise
    base_sum = {1'b0, base_cur} + (READING_W + 1)'(baseline_step);
    if (base_cur != '0 && s1_reading > base_cur) begin
      baseline_next = (base_sum > {1'b0, BASELINE_MAX}) ? BASELINE_MAX
                                                         : base_sum[READING_W-1:0];
    end else begin
      baseline_next = s1_reading;
    end

    hist_shift = {hist_cur[6:0], 1'b0};
    hist_inc   = (hist_cur != HIST_MAX) ? hist_cur + 8'd1 : hist_cur;

    // hysteresis: previous state picks the margin
    if (timer_mode) begin
      margin = (hist_cur != '0) ? hold_margin : enter_margin;
    end else begin
      margin = hist_cur[0] ? hold_margin : enter_margin;
    end
    thresh   = {1'b0, baseline_next} + (READING_W + 1)'(margin);
    touch_on = {1'b0, s1_reading} > thresh;

    deb_len     = (debounce_length == '0) ? 3'd1 : debounce_length;
    deb_len_p1  = {1'b0, deb_len} + 4'd1;
    mask9       = (9'd1 << deb_len_p1) - 9'd1;
    pat_on9     = (9'd1 << deb_len) - 9'd1;
    hist_masked = '0;

    code = EV_NONE;
    if (timer_mode) begin
      if (touch_on) begin
        history_next = hist_inc;
        if (hist_inc == long_hold_ticks) begin
          code = EV_LONG_MATCH;
        end else if (hist_inc == short_hold_ticks) begin
          code = EV_SHORT_MATCH;
        end
      end else begin
        history_next = '0;
        if (hist_cur > long_hold_ticks) begin
          code = EV_NONE;
        end else if (hist_cur > short_hold_ticks) begin
          code = EV_SHORT_PRESS;
        end
      end
    end else begin
      history_next = {hist_shift[7:1], touch_on};
      hist_masked  = history_next & mask9[7:0];
      // off pattern is the on pattern shifted up by one
      if (hist_masked == pat_on9[7:0]) begin
        code = EV_ON_EDGE;
      end else if (hist_masked == (mask9[7:0] - 8'd1)) begin
        code = EV_OFF_EDGE;
      end
    end

    if (warm || !ch_valid) begin
      code = EV_NONE;
    end
    st_we = adv && !warm && ch_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_count <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        baseline[i] <= '0;
        history[i]  <= '0;
      end
    end else begin
      if (adv && warm) begin
        warmup_count <= warmup_count + 8'd1;
      end
      if (st_we) begin
        baseline[idx] <= baseline_next;
        history[idx]  <= history_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      event_code <= code;
    end
  end

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("advanced request did not reach the result register");

  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a request in the input stage");

  a_warm_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && (warm || !ch_valid)) |=> event_code == EV_NONE)
    else $error("warmup or invalid channel gave a nonzero event");

  a_warm_count: assert property (@(posedge clk) disable iff (rst)
    (adv && warm) |=> warmup_count == $past(warmup_count) + 8'd1)
    else $error("warmup count did not advance");

endmodule

[tb/tb_touch_channel_evaluator_core.sv]
// Self-checking testbench for touch_channel_evaluator_core with an event scoreboard.
`timescale 1ns / 1ps
module tb_touch_channel_evaluator_core;
  import tce_pkg::*;

  localparam int NUM_CH = 4;
  localparam int MAX_READING = 8184;

  // Tracks per-channel baseline/history and queues the expected event codes.
  class touch_event_scoreboard;
    logic [3:0]          mode_mask;
    logic [MARGIN_W-1:0] hold_m;
    logic [MARGIN_W-1:0] enter_m;
    logic [3:0]          step;
    logic [7:0]          short_t;
    logic [7:0]          long_t;
    logic [2:0]          deb;
    logic [7:0]          warm_t;
    logic [7:0]          warm_cnt;
    logic [READING_W-1:0] base_lvl[NUM_CH];
    logic [7:0]          hist[NUM_CH];
    logic [1:0]          expected_events[$];
    int                  errors;
    int                  checked;
    int                  seen[4];

    function new();
      mode_mask = RST_TIMER_MODE_MASK;
      hold_m    = RST_HOLD_MARGIN;
      enter_m   = RST_ENTER_MARGIN;
      step      = RST_BASELINE_STEP;
      short_t   = RST_SHORT_HOLD_TICKS;
      long_t    = RST_LONG_HOLD_TICKS;
      deb       = RST_DEBOUNCE_LENGTH;
      warm_t    = RST_WARMUP_TICKS;
      warm_cnt  = '0;
      foreach (base_lvl[i]) begin
        base_lvl[i] = '0;
        hist[i] = '0;
      end
      errors = 0;
      checked = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void apply_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
      case (r)
        REG_TIMER_MODE_MASK:  mode_mask = v[3:0];
        REG_HOLD_MARGIN:      hold_m    = v[MARGIN_W-1:0];
        REG_ENTER_MARGIN:     enter_m   = v[MARGIN_W-1:0];
        REG_BASELINE_STEP:    step      = v[3:0];
        REG_SHORT_HOLD_TICKS: short_t   = v[7:0];
        REG_LONG_HOLD_TICKS:  long_t    = v[7:0];
        REG_DEBOUNCE_LENGTH:  deb       = v[2:0];
        REG_WARMUP_TICKS:     warm_t    = v[7:0];
        default: ;
      endcase
    endfunction

    // sum is formed in int so it cannot wrap
    function bit above(logic [READING_W-1:0] rd, logic [READING_W-1:0] b,
                       logic [MARGIN_W-1:0] m);
      return int'(rd) > int'(b) + int'(m);
    endfunction

    function logic [1:0] timer_event(int ch, logic [READING_W-1:0] rd);
      logic [7:0] h;
      h = hist[ch];
      if (above(rd, base_lvl[ch], (h != 0) ? hold_m : enter_m)) begin
        if (h != HIST_MAX) h = h + 8'd1;
        hist[ch] = h;
        if (h == long_t) return EV_LONG_MATCH;
        if (h == short_t) return EV_SHORT_MATCH;
        return EV_NONE;
      end
      hist[ch] = '0;
      if (h > long_t) return EV_NONE;
      if (h > short_t) return EV_SHORT_PRESS;
      return EV_NONE;
    endfunction

    function logic [1:0] real_event(int ch, logic [READING_W-1:0] rd);
      int d;
      logic [7:0] h;
      logic [7:0] win;
      logic [7:0] pat_on;
      logic [7:0] pat_off;
      d = (deb == 0) ? 1 : int'(deb);
      h = {hist[ch][6:0], 1'b0};
      win = 8'((1 << (d + 1)) - 1);
      pat_on = 8'((1 << d) - 1);
      pat_off = 8'((1 << (d + 1)) - 2);
      // previous sample sits in bit 1 after the shift
      if (above(rd, base_lvl[ch], h[1] ? hold_m : enter_m)) h[0] = 1'b1;
      hist[ch] = h;
      if ((h & win) == pat_on) return EV_ON_EDGE;
      if ((h & win) == pat_off) return EV_OFF_EDGE;
      return EV_NONE;
    endfunction

    function void note_request(logic [2:0] ch, logic [READING_W-1:0] rd);
      logic [1:0] ev;
      int sum;
      ev = EV_NONE;
      if (warm_cnt < warm_t) begin
        warm_cnt = warm_cnt + 8'd1;
      end else if (int'(ch) < NUM_CH) begin
        if (base_lvl[ch] != 0 && rd > base_lvl[ch]) begin
          sum = int'(base_lvl[ch]) + int'(step);
          base_lvl[ch] = (sum > int'(BASELINE_MAX)) ? BASELINE_MAX : READING_W'(sum);
        end else begin
          base_lvl[ch] = rd;
        end
        ev = mode_mask[ch] ? timer_event(ch, rd) : real_event(ch, rd);
      end
      expected_events.push_back(ev);
    endfunction

    function void check_event(logic [1:0] got);
      logic [1:0] exp_ev;
      if (expected_events.size() == 0) begin
        $error("event_code: no request pending, got %0d", got);
        errors++;
        return;
      end
      exp_ev = expected_events.pop_front();
      checked++;
      if (got !== exp_ev) begin
        $error("event_code mismatch: expected %0d, got %0d", exp_ev, got);
        errors++;
      end else begin
        seen[got]++;
      end
    endfunction

    function int pending_count();
      return expected_events.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           channel = '0;
  logic [READING_W-1:0] summed_reading = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           event_code;

  touch_event_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_off_req = 0;
  int settings_used = 0;
  int seg_left[NUM_CH];
  bit seg_on[NUM_CH];

  touch_channel_evaluator_core #(.CHANNELS(NUM_CH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .channel(channel),
    .summed_reading(summed_reading),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_code(event_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls plus an occasional long hold-off.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req != 0) begin
        stall_left = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_event(event_code);
  end

  function automatic void set_idle(int mode);
    tx_idle_pct = (mode == 1) ? 71 : (mode == 3) ? 35 : 0;
    rx_stall_pct = (mode == 2) ? 71 : (mode == 3) ? 35 : 0;
  endfunction

  task automatic send_req(logic [2:0] ch, logic [READING_W-1:0] rd);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    summed_reading <= rd;
    do @(posedge clk); while (!in_ready);
    sb.note_request(ch, rd);
  endtask

  // Drop valid, then wait for every outstanding event plus pipeline slack.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data <= CFG_W'(v);
    sb.apply_reg(r, CFG_W'(v));
  endtask

  task automatic set_config(int mask, int hold, int enter, int stp, int shrt, int lng,
                            int dbl, int warm);
    write_reg(REG_TIMER_MODE_MASK, mask);
    write_reg(REG_HOLD_MARGIN, hold);
    write_reg(REG_ENTER_MARGIN, enter);
    write_reg(REG_BASELINE_STEP, stp);
    write_reg(REG_SHORT_HOLD_TICKS, shrt);
    write_reg(REG_LONG_HOLD_TICKS, lng);
    write_reg(REG_DEBOUNCE_LENGTH, dbl);
    write_reg(REG_WARMUP_TICKS, warm);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Reading that lands clearly on or off relative to the tracked baseline.
  function automatic logic [READING_W-1:0] pick_reading(int ch, bit press);
    int b;
    int m;
    int r;
    b = sb.base_lvl[ch];
    m = (sb.hold_m > sb.enter_m) ? sb.hold_m : sb.enter_m;
    if (press) r = b + m + $urandom_range(1, 400);
    else r = b - $urandom_range(0, 30);
    if (r < 0) r = 0;
    if (r > MAX_READING) r = MAX_READING;
    return READING_W'(r);
  endfunction

  // Press/release segments per channel; focus_ch (if >= 0) is held on throughout.
  task automatic run_phase(int n, int start_mode, int press_max, int focus_ch,
                           int focus_pct, int hold_off_at);
    int ch;
    logic [READING_W-1:0] rd;
    for (int i = 0; i < NUM_CH; i++) begin
      seg_left[i] = 0;
      seg_on[i] = 1'b0;
    end
    if (focus_ch >= 0) begin
      seg_on[focus_ch] = 1'b1;
      seg_left[focus_ch] = 100000;
    end
    for (int i = 0; i < n; i++) begin
      set_idle((start_mode + i / 60) % 4);
      if (i == hold_off_at) hold_off_req = 150;
      if (focus_ch >= 0 && $urandom_range(0, 99) < focus_pct) ch = focus_ch;
      else if ($urandom_range(0, 15) == 0) ch = $urandom_range(NUM_CH, 7);
      else ch = $urandom_range(0, NUM_CH - 1);
      if (ch >= NUM_CH) begin
        rd = READING_W'($urandom_range(0, MAX_READING));
      end else begin
        if (seg_left[ch] == 0) begin
          seg_on[ch] = !seg_on[ch];
          seg_left[ch] = seg_on[ch] ? $urandom_range(1, press_max) : $urandom_range(1, 8);
        end
        seg_left[ch]--;
        if (ch != focus_ch && $urandom_range(0, 11) == 0)
          rd = READING_W'($urandom_range(0, MAX_READING));
        else
          rd = pick_reading(ch, seg_on[ch]);
      end
      send_req(3'(ch), rd);
    end
    drain();
  endtask

  initial begin
    int s;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idle(0);

    // default warmup still active
    send_req(3'd0, 13'd8184);
    send_req(3'd7, 13'd0);
    drain();

    // ch1/ch3 timer, zero margins, max step, debounce 0 -> 1, warmup ends after one more
    set_config(4'b1010, 0, 0, 15, 2, 3, 0, 3);
    send_req(3'd2, 13'h1555);
    send_req(3'd4, 13'd100);
    send_req(3'd7, 13'd8184);
    send_req(3'd0, 13'd0);       // zero reading keeps baseline unloaded
    send_req(3'd0, 13'd8180);
    send_req(3'd0, 13'd8184);    // baseline rise clips at max
    send_req(3'd0, 13'd100);
    send_req(3'd0, 13'h0aaa);
    send_req(3'd0, 13'd8184);
    send_req(3'd0, 13'd1);
    send_req(3'd1, 13'd50);
    repeat (4) send_req(3'd1, 13'd4000);
    send_req(3'd1, 13'd10);      // release past long hold
    repeat (3) send_req(3'd1, 13'd4000);
    send_req(3'd1, 13'd10);      // release between short and long
    drain();

    // mode swap keeps histories; equal hold thresholds
    set_config(4'b0101, 1023, 1023, 0, 2, 2, 7, 0);
    send_req(3'd0, 13'd8184);
    send_req(3'd1, 13'd5000);
    send_req(3'd2, 13'd100);
    send_req(3'd2, 13'd4000);
    send_req(3'd2, 13'd4000);
    drain();

    set_config(0, 40, 120, 3, 5, 20, 7, 0);
    run_phase(80, 1, 14, -1, 0, -1);

    set_config(4'b1111, 1023, 1023, 0, 0, 255, 1, 0);
    run_phase(80, 2, 10, -1, 0, 20);

    s = $urandom_range(1, 8);
    set_config($urandom_range(0, 15), $urandom_range(0, 200), $urandom_range(0, 400),
               $urandom_range(0, 15), s, s + $urandom_range(1, 12), $urandom_range(0, 7), 0);
    run_phase(80, 3, 20, -1, 0, -1);

    // one channel held long enough to pin its on-counter at the top
    s = $urandom_range(0, NUM_CH - 1);
    set_config(4'b1111, 0, 0, 0, 200, 255, 3, 0);
    send_req(3'(s), 13'd1000);
    run_phase(290, 0, 12, s, 92, -1);

    s = $urandom_range(1, 6);
    set_config($urandom_range(0, 15), 60, 90, 15, s, s, 2, $urandom_range(0, 8));
    run_phase(60, 1, 10, -1, 0, -1);

    set_config($urandom_range(0, 15), 500, 700, 7, 255, 0, 5, 255);
    run_phase(10, 2, 10, -1, 0, -1);

    repeat (8) @(posedge clk);
    $display("Checked %0d events over %0d register settings: warmup, bad channels,",
             sb.checked, settings_used);
    $display("  baseline clipping, mode swaps, full-scale holds; codes 0/1/2/3 = %0d/%0d/%0d/%0d",
             sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3]);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[touch_channel_evaluator_core.f]
hw/rtl/tce_pkg.sv
hw/rtl/touch_channel_evaluator_core.sv
tb/tb_touch_channel_evaluator_core.sv
